// ===== rtl/kvt_pkg.sv =====
// Shared types and codes for the key/value table.
package kvt_pkg;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_DELETE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] lookup_key;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [3:0]  slot_index;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic free;
   } match_flags_type;

endpackage

// ===== rtl/kvt_ram.sv =====
// Single write port, single registered read port memory.
module kvt_ram #(
   parameter int DEPTH     = 16,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/kvt_match.sv =====
// Shared key comparator: tracks first matching slot and first free slot over a scan.
module kvt_match #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           sample,
   input  logic [IDX_BITS-1:0]            sample_idx,
   input  logic [KEY_BITS:0]              tag_data,
   input  logic [VALUE_BITS-1:0]          value_data,
   input  logic [KEY_BITS-1:0]            lookup_key,
   output kvt_pkg::match_flags_type       flags,
   output logic [IDX_BITS-1:0]            hit_idx,
   output logic [VALUE_BITS-1:0]          hit_value,
   output logic [IDX_BITS-1:0]            free_idx
);

   logic                  hit_ff, hit_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  slot_valid;
   logic                  key_equal;

   assign slot_valid = tag_data[KEY_BITS];
   assign key_equal  = (tag_data[KEY_BITS-1:0] == lookup_key);

   always_comb begin
      hit_in       = hit_ff;
      free_in      = free_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      free_idx_in  = free_idx_ff;
      if (clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (sample) begin
         if (!hit_ff && slot_valid && key_equal) begin
            hit_in       = 1'b1;
            hit_idx_in   = sample_idx;
            hit_value_in = value_data;
         end
         if (!free_ff && !slot_valid) begin
            free_in     = 1'b1;
            free_idx_in = sample_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   assign flags.hit  = hit_ff;
   assign flags.free = free_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_value  = hit_value_ff;
   assign free_idx   = free_idx_ff;

endmodule

// ===== rtl/fixed_capacity_key_value_table_core.sv =====
// Top level of the fixed-capacity key/value table: sequencer, tag/value memories, comparator.
// A request is taken when start is high and busy is low. Each request then passes through the
// scan, drain and update states before the next accept: in the scan the single comparator examines
// one slot per cycle through the tag memory read port, the drain state empties the read pipeline,
// the update state performs the table update, and the result beat is on rsp_item for exactly
// one cycle with rsp_valid high; busy is already low in that cycle, so the next start may be
// taken then. The receiver cannot hold results off. After reset the block runs a clearing pass
// over every slot of the tag memory with busy high before the first request is taken.
module fixed_capacity_key_value_table_core #(
   parameter int TABLE_ENTRIES = 16,
   parameter int KEY_BITS      = 32,
   parameter int VALUE_BITS    = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kvt_pkg::req_type req_item,
   output logic             rsp_valid,
   output kvt_pkg::rsp_type rsp_item
);

   localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   addr_ff, addr_in;
   logic                  sample_ff, sample_in;
   logic [IDX_BITS-1:0]   sample_idx_ff, sample_idx_in;
   logic [1:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kvt_pkg::rsp_type      rsp_ff, rsp_in;

   logic [KEY_BITS+31:0]   key_wide;
   logic [VALUE_BITS+31:0] value_wide;
   logic [VALUE_BITS+31:0] read_wide;
   logic [IDX_BITS+3:0]    idx_wide;

   logic                  tag_we;
   logic                  value_we;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [KEY_BITS:0]     tag_wdata;
   logic [KEY_BITS:0]     tag_rdata;
   logic [VALUE_BITS-1:0] value_rdata;

   kvt_pkg::match_flags_type flags;
   logic [IDX_BITS-1:0]      hit_idx;
   logic [VALUE_BITS-1:0]    hit_value;
   logic [IDX_BITS-1:0]      free_idx;
   logic                     accept;

   logic                  upd_tag_we;
   logic                  upd_value_we;
   logic [IDX_BITS-1:0]   upd_addr;
   logic                  upd_valid;
   logic [1:0]            upd_status;
   logic [IDX_BITS-1:0]   upd_idx;
   logic [VALUE_BITS-1:0] upd_rvalue;

   assign accept     = start && (state_ff == ST_IDLE);
   assign key_wide   = {{KEY_BITS{1'b0}}, req_item.lookup_key};
   assign value_wide = {{VALUE_BITS{1'b0}}, req_item.write_value};

   kvt_ram #(
      .DEPTH     (TABLE_ENTRIES),
      .WIDTH     (KEY_BITS + 1),
      .ADDR_BITS (IDX_BITS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_addr),
      .wr_data (tag_wdata),
      .rd_addr (addr_ff),
      .rd_data (tag_rdata)
   );

   kvt_ram #(
      .DEPTH     (TABLE_ENTRIES),
      .WIDTH     (VALUE_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (addr_ff),
      .rd_data (value_rdata)
   );

   kvt_match #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .sample     (sample_ff),
      .sample_idx (sample_idx_ff),
      .tag_data   (tag_rdata),
      .value_data (value_rdata),
      .lookup_key (key_ff),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .hit_value  (hit_value),
      .free_idx   (free_idx)
   );

   // table update and result for the finished scan
   always_comb begin
      upd_tag_we   = 1'b0;
      upd_value_we = 1'b0;
      upd_addr     = hit_idx;
      upd_valid    = 1'b0;
      upd_status   = kvt_pkg::STATUS_NOT_FOUND;
      upd_idx      = '0;
      upd_rvalue   = '0;
      case (op_ff)
         kvt_pkg::OP_READ: begin
            if (flags.hit) begin
               upd_status = kvt_pkg::STATUS_OK;
               upd_idx    = hit_idx;
               upd_rvalue = hit_value;
            end
         end
         kvt_pkg::OP_WRITE: begin
            if (flags.hit) begin
               upd_value_we = 1'b1;
               upd_status   = kvt_pkg::STATUS_OK;
               upd_idx      = hit_idx;
            end else if (flags.free) begin
               upd_tag_we   = 1'b1;
               upd_value_we = 1'b1;
               upd_valid    = 1'b1;
               upd_addr     = free_idx;
               upd_status   = kvt_pkg::STATUS_OK;
               upd_idx      = free_idx;
            end else begin
               upd_status = kvt_pkg::STATUS_FULL;
            end
         end
         kvt_pkg::OP_DELETE: begin
            if (flags.hit) begin
               upd_tag_we = 1'b1;
               upd_status = kvt_pkg::STATUS_OK;
               upd_idx    = hit_idx;
            end
         end
         default: begin
            upd_status = kvt_pkg::STATUS_NOT_FOUND;
         end
      endcase
   end

   assign read_wide = {32'd0, upd_rvalue};
   assign idx_wide  = {4'd0, upd_idx};

   always_comb begin
      tag_we    = 1'b0;
      value_we  = 1'b0;
      wr_addr   = upd_addr;
      tag_wdata = {upd_valid, key_ff};
      case (state_ff)
         ST_CLEAR: begin
            tag_we    = 1'b1;
            wr_addr   = addr_ff;
            tag_wdata = '0;
         end
         ST_UPDATE: begin
            tag_we   = upd_tag_we;
            value_we = upd_value_we;
         end
         default: begin
            tag_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      sample_in     = (state_ff == ST_SCAN);
      sample_idx_in = addr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.opcode;
               key_in   = key_wide[KEY_BITS-1:0];
               value_in = value_wide[VALUE_BITS-1:0];
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = upd_status;
            rsp_in.read_value     = read_wide[31:0];
            rsp_in.slot_index     = idx_wide[3:0];
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_idx_ff <= sample_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         sample_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         sample_ff    <= sample_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_beat_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   a_beat_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_UPDATE))
      else $error("result beat without update");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not start a scan");

   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != kvt_pkg::STATUS_OK))
         |-> (rsp_item.slot_index == 4'd0 && rsp_item.read_value == 32'd0))
      else $error("failed request carries nonzero payload");

endmodule
